/* hw/rtl/waypoint_p_velocity_tracker_top_assert.svh */
// Assertion macros for the waypoint velocity tracker checker.
`ifndef WAYPOINT_P_VELOCITY_TRACKER_TOP_ASSERT_SVH
`define WAYPOINT_P_VELOCITY_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WPVT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("waypoint tracker check failed");

// Next-cycle implication, disabled during reset.
`define WPVT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("waypoint tracker check failed");

`endif

/* hw/rtl/wpvt_pkg.sv */
// Shared constants, codes and control types of the waypoint velocity tracker.
package wpvt_pkg;

    localparam int MAX_WAYPOINTS = 1024;
    localparam int FRAC_BITS     = 16;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);

    localparam int IDX_W     = 11;
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 10;
    localparam int POS_W     = 32;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 2;

    localparam int E_W     = POS_W + 1;
    localparam int A_W     = E_W;
    localparam int V_W     = CFG_W + A_W - FRAC_BITS;
    localparam int T_W     = 31;
    localparam int NUM_W   = T_W + CFG_W;
    localparam int D2_W    = 2 * CFG_W + 2;
    localparam int SUM_W   = 2 * T_W + 2;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int MUL_W   = A_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SH_W    = $clog2(V_W - T_W + 1);
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] LAST_COMP = 2'd2;

    localparam logic [CMD_W-1:0] CMD_POSE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd3;

    localparam logic [CFG_W-1:0] GAIN_RST   = CFG_W'((7 * (1 << FRAC_BITS)) / 10);
    localparam logic [CFG_W-1:0] SPEED_RST  = CFG_W'(1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RADIUS_RST = CFG_W'((2 * (1 << FRAC_BITS)) / 10);

    typedef enum logic [3:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_ERR,
        DP_D2,
        DP_RRSQ,
        DP_ADVANCE,
        DP_GMUL,
        DP_SHIFT,
        DP_TSQ,
        DP_SLSQ,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_PMUL,
        DP_DIV_STEP,
        DP_DIV_END,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic go;
        logic near;
        logic over;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/wpvt_dp.sv */
// Datapath: registers, waypoint tables, shared multiplier, square root and divider.
module wpvt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wpvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpvt_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                accept,
    input  logic [wpvt_pkg::CMD_W-1:0]          cmd,
    input  logic [wpvt_pkg::SLOT_W-1:0]         slot,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_x,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_y,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_z,
    input  wpvt_pkg::dp_cmd_t                   ctl,
    output wpvt_pkg::dp_status_t                sts,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                vel_valid,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_x,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_y,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_z,
    output logic                                reached,
    output logic                                finished,
    output logic [wpvt_pkg::IDX_W-1:0]          target_index
);
    import wpvt_pkg::*;

    logic [IDX_W-1:0]  count_reg;
    logic [CFG_W-1:0]  gain_reg, sl_reg, rr_reg;
    logic [POS_W-1:0]  pose_reg [3];
    logic              pose_valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CMD_W-1:0]  cmd_reg;

    logic [POS_W-1:0]  mem_x [MAX_WAYPOINTS];
    logic [POS_W-1:0]  mem_y [MAX_WAYPOINTS];
    logic [POS_W-1:0]  mem_z [MAX_WAYPOINTS];
    logic [POS_W-1:0]  rd_reg [3];

    logic [A_W-1:0]    a_reg [3];
    logic [2:0]        neg_reg;
    logic              small_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [2*CFG_W-1:0] rrsq_reg, slsq_reg;
    logic [V_W-1:0]    v_reg [3];
    logic [T_W-1:0]    t_reg [3];
    logic              snz_reg;
    logic [SUM_W-1:0]  sum_reg, src_reg;
    logic [ROOT_W+2:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [ROOT_W:0]   drem_reg;
    logic              vflag_reg, rflag_reg;

    logic              out_valid_reg, vel_valid_reg, reached_reg, finished_reg;
    logic [POS_W-1:0]  vel_reg [3];
    logic [IDX_W-1:0]  target_reg;

    logic [IDX_W-1:0]  eff_c;
    logic [MUL_W-1:0]  ma_c, mb_c;
    logic [PROD_W-1:0] prod_c;
    logic signed [E_W-1:0] e_c [3];
    logic [A_W-1:0]    a_c [3];
    logic [V_W-1:0]    orv_c;
    logic [SH_W-1:0]   sh_c;
    logic [ROOT_W+2:0] rem_sh_c, trial_c;
    logic [ROOT_W:0]   n_c;
    logic [ROOT_W+1:0] dsh_c, dsub_c;
    logic              dge_c;
    logic [V_W-1:0]    vs_c [3];
    logic              slot_ok_c;

    assign eff_c = (32'(count_reg) > MAX_WAYPOINTS) ? IDX_W'(MAX_WAYPOINTS) : count_reg;
    assign slot_ok_c = 32'(slot) < MAX_WAYPOINTS;

    assign sts.is_tick  = cmd_reg == CMD_TICK;
    assign sts.go       = pose_valid_reg && (idx_reg < eff_c);
    assign sts.near     = small_reg && (d2_reg < D2_W'(rrsq_reg));
    assign sts.over     = snz_reg || (sum_reg > SUM_W'(slsq_reg));
    assign sts.out_free = !out_valid_reg || !out_stall;

    // Shared multiplier operand selection
    always_comb
    begin
        ma_c = '0;
        mb_c = '0;
        case (ctl.op)
            DP_D2:
            begin
                ma_c = MUL_W'(a_reg[ctl.comp][CFG_W-1:0]);
                mb_c = MUL_W'(a_reg[ctl.comp][CFG_W-1:0]);
            end
            DP_RRSQ:
            begin
                ma_c = MUL_W'(rr_reg);
                mb_c = MUL_W'(rr_reg);
            end
            DP_GMUL:
            begin
                ma_c = MUL_W'(gain_reg);
                mb_c = a_reg[ctl.comp];
            end
            DP_TSQ:
            begin
                ma_c = MUL_W'(t_reg[ctl.comp]);
                mb_c = MUL_W'(t_reg[ctl.comp]);
            end
            DP_SLSQ:
            begin
                ma_c = MUL_W'(sl_reg);
                mb_c = MUL_W'(sl_reg);
            end
            DP_PMUL:
            begin
                ma_c = MUL_W'(t_reg[ctl.comp]);
                mb_c = MUL_W'(sl_reg);
            end
            default:
            begin
                ma_c = '0;
                mb_c = '0;
            end
        endcase
    end

    assign prod_c = {{MUL_W{1'b0}}, ma_c} * {{MUL_W{1'b0}}, mb_c};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_c[i] = $signed({rd_reg[i][POS_W-1], rd_reg[i]})
                   - $signed({pose_reg[i][POS_W-1], pose_reg[i]});
            a_c[i] = e_c[i][E_W-1] ? A_W'(-e_c[i]) : A_W'(e_c[i]);
            vs_c[i] = neg_reg[i] ? (~v_reg[i] + V_W'(1)) : v_reg[i];
        end
    end

    // Smallest shift that brings every velocity magnitude under the 31-bit range
    always_comb
    begin
        orv_c = v_reg[0] | v_reg[1] | v_reg[2];
        sh_c  = '0;
        for (int j = 0; j < V_W - T_W; j++)
        begin
            if (orv_c[T_W + j])
            begin
                sh_c = SH_W'(j + 1);
            end
        end
    end

    assign rem_sh_c = {rem_reg[ROOT_W:0], src_reg[SUM_W-1 -: 2]};
    assign trial_c  = {1'b0, root_reg, 2'b01};
    // Round the floor root up unless the square was exact
    assign n_c      = {1'b0, root_reg} + (ROOT_W+1)'(rem_reg != '0);
    assign dsh_c    = {drem_reg, num_reg[NUM_W-1]};
    assign dge_c    = dsh_c >= {1'b0, n_c};
    assign dsub_c   = dsh_c - {1'b0, n_c};

    always_ff @(posedge clk)
    begin
        if (accept && (cmd == CMD_LOAD) && slot_ok_c)
        begin
            mem_x[WP_AW'(slot)] <= pos_x;
            mem_y[WP_AW'(slot)] <= pos_y;
            mem_z[WP_AW'(slot)] <= pos_z;
        end
        rd_reg[0] <= mem_x[idx_reg[WP_AW-1:0]];
        rd_reg[1] <= mem_y[idx_reg[WP_AW-1:0]];
        rd_reg[2] <= mem_z[idx_reg[WP_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            gain_reg       <= GAIN_RST;
            sl_reg         <= SPEED_RST;
            rr_reg         <= RADIUS_RST;
            pose_reg[0]    <= '0;
            pose_reg[1]    <= '0;
            pose_reg[2]    <= '0;
            pose_valid_reg <= 1'b0;
            idx_reg        <= '0;
            vflag_reg      <= 1'b0;
            rflag_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COUNT:  count_reg <= cfg_data[IDX_W-1:0];
                    CFG_GAIN:   gain_reg  <= cfg_data;
                    CFG_SPEED:  sl_reg    <= cfg_data;
                    CFG_RADIUS: rr_reg    <= cfg_data;
                    default:    count_reg <= count_reg;
                endcase
            end
            case (ctl.op)
                DP_CAPTURE:
                begin
                    vflag_reg <= 1'b0;
                    rflag_reg <= 1'b0;
                    if (cmd == CMD_POSE)
                    begin
                        pose_reg[0]    <= pos_x;
                        pose_reg[1]    <= pos_y;
                        pose_reg[2]    <= pos_z;
                        pose_valid_reg <= 1'b1;
                    end
                end
                DP_ADVANCE:
                begin
                    idx_reg   <= idx_reg + IDX_W'(1);
                    rflag_reg <= 1'b1;
                    vflag_reg <= (idx_reg + IDX_W'(1)) >= eff_c;
                end
                DP_GMUL:
                begin
                    vflag_reg <= 1'b1;
                end
                default:
                begin
                    vflag_reg <= vflag_reg;
                end
            endcase
            if (ctl.op == DP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            DP_CAPTURE:
            begin
                cmd_reg  <= cmd;
                v_reg[0] <= '0;
                v_reg[1] <= '0;
                v_reg[2] <= '0;
            end
            DP_ERR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]   <= a_c[i];
                    neg_reg[i] <= e_c[i][E_W-1];
                end
                small_reg <= (a_c[0][A_W-1:CFG_W] == '0) && (a_c[1][A_W-1:CFG_W] == '0)
                          && (a_c[2][A_W-1:CFG_W] == '0);
            end
            DP_D2:
            begin
                d2_reg <= ((ctl.comp == 2'd0) ? D2_W'(0) : d2_reg)
                        + D2_W'(prod_c[2*CFG_W-1:0]);
            end
            DP_RRSQ:
            begin
                rrsq_reg <= prod_c[2*CFG_W-1:0];
            end
            DP_GMUL:
            begin
                v_reg[ctl.comp] <= prod_c[FRAC_BITS +: V_W];
            end
            DP_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    t_reg[i] <= T_W'(v_reg[i] >> sh_c);
                end
                snz_reg <= sh_c != '0;
            end
            DP_TSQ:
            begin
                sum_reg <= ((ctl.comp == 2'd0) ? SUM_W'(0) : sum_reg)
                         + SUM_W'(prod_c[2*T_W-1:0]);
            end
            DP_SLSQ:
            begin
                slsq_reg <= prod_c[2*CFG_W-1:0];
            end
            DP_SQRT_INIT:
            begin
                src_reg  <= sum_reg;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            DP_SQRT_STEP:
            begin
                src_reg <= {src_reg[SUM_W-3:0], 2'b00};
                if (rem_sh_c >= trial_c)
                begin
                    rem_reg  <= rem_sh_c - trial_c;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh_c;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            DP_PMUL:
            begin
                num_reg  <= prod_c[NUM_W-1:0];
                drem_reg <= '0;
            end
            DP_DIV_STEP:
            begin
                drem_reg <= dge_c ? dsub_c[ROOT_W:0] : dsh_c[ROOT_W:0];
                num_reg  <= {num_reg[NUM_W-2:0], dge_c};
            end
            DP_DIV_END:
            begin
                v_reg[ctl.comp] <= V_W'(num_reg);
            end
            DP_EMIT:
            begin
                vel_valid_reg <= vflag_reg;
                reached_reg   <= rflag_reg;
                finished_reg  <= idx_reg >= eff_c;
                target_reg    <= idx_reg;
                for (int i = 0; i < 3; i++)
                begin
                    vel_reg[i] <= vs_c[i][POS_W-1:0];
                end
            end
            default:
            begin
                cmd_reg <= cmd_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign vel_valid    = vel_valid_reg;
    assign vel_x        = vel_reg[0];
    assign vel_y        = vel_reg[1];
    assign vel_z        = vel_reg[2];
    assign reached      = reached_reg;
    assign finished     = finished_reg;
    assign target_index = target_reg;

endmodule

/* hw/rtl/wpvt_ctrl.sv */
// Controller: sequences the datapath through one item at a time.
module wpvt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  wpvt_pkg::dp_status_t  sts,
    output wpvt_pkg::dp_cmd_t     ctl
);
    import wpvt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TCHK,
        S_D2,
        S_RRSQ,
        S_DECIDE,
        S_GMUL,
        S_SHIFT,
        S_TSQ,
        S_SLSQ,
        S_OVCHK,
        S_SQRT,
        S_PMUL,
        S_DIV,
        S_DEND,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        comp_reg, comp_next;

    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        ctl.op     = DP_NONE;
        ctl.comp   = comp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = DP_CAPTURE;
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                ctl.op    = DP_ERR;
                comp_next = 2'd0;
                state_next = (sts.is_tick && sts.go) ? S_D2 : S_EMIT;
            end
            S_D2:
            begin
                ctl.op = DP_D2;
                if (comp_reg == LAST_COMP)
                begin
                    state_next = S_RRSQ;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            S_RRSQ:
            begin
                ctl.op     = DP_RRSQ;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                comp_next = 2'd0;
                if (sts.near)
                begin
                    ctl.op     = DP_ADVANCE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_GMUL;
                end
            end
            S_GMUL:
            begin
                ctl.op = DP_GMUL;
                if (comp_reg == LAST_COMP)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            S_SHIFT:
            begin
                ctl.op     = DP_SHIFT;
                comp_next  = 2'd0;
                state_next = S_TSQ;
            end
            S_TSQ:
            begin
                ctl.op = DP_TSQ;
                if (comp_reg == LAST_COMP)
                begin
                    state_next = S_SLSQ;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            S_SLSQ:
            begin
                ctl.op     = DP_SLSQ;
                state_next = S_OVCHK;
            end
            S_OVCHK:
            begin
                ctl.op     = DP_SQRT_INIT;
                cnt_next   = '0;
                comp_next  = 2'd0;
                state_next = sts.over ? S_SQRT : S_EMIT;
            end
            S_SQRT:
            begin
                ctl.op = DP_SQRT_STEP;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_PMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_PMUL:
            begin
                ctl.op     = DP_PMUL;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctl.op = DP_DIV_STEP;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DEND;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DEND:
            begin
                ctl.op = DP_DIV_END;
                if (comp_reg == LAST_COMP)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_PMUL;
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    ctl.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

endmodule

/* hw/rtl/waypoint_p_velocity_tracker_top.sv */
// Pose, load and unknown items, and a tick that finds no pose or no waypoint, go
// straight to the result; a reached waypoint passes a distance check; a velocity adds
// gain and limit; a limited one a 32-step square root and three 52-step divisions.
// A new item is accepted the cycle after the result enters the output register.
// Reset (rst_n low, asynchronous) clears pose, index and registers to defaults;
// waypoint tables are not cleared and must be loaded before use.
module waypoint_p_velocity_tracker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wpvt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wpvt_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wpvt_pkg::CMD_W-1:0]          cmd,
    input  logic [wpvt_pkg::SLOT_W-1:0]         slot,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_x,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_y,
    input  logic signed [wpvt_pkg::POS_W-1:0]   pos_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                vel_valid,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_x,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_y,
    output logic signed [wpvt_pkg::POS_W-1:0]   vel_z,
    output logic                                reached,
    output logic                                finished,
    output logic [wpvt_pkg::IDX_W-1:0]          target_index
);
    import wpvt_pkg::*;

    dp_cmd_t    ctl;
    dp_status_t sts;
    logic       accept;

    assign accept = in_valid && !in_stall;

    wpvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    wpvt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .cmd          (cmd),
        .slot         (slot),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .ctl          (ctl),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .vel_valid    (vel_valid),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .reached      (reached),
        .finished     (finished),
        .target_index (target_index)
    );

endmodule

/* hw/rtl/wpvt_checker.sv */
// Port-level checker of the waypoint velocity tracker, bound to the top level.
`include "waypoint_p_velocity_tracker_top_assert.svh"

module wpvt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                vel_valid,
    input logic signed [wpvt_pkg::POS_W-1:0]   vel_x,
    input logic signed [wpvt_pkg::POS_W-1:0]   vel_y,
    input logic signed [wpvt_pkg::POS_W-1:0]   vel_z,
    input logic                                reached,
    input logic                                finished,
    input logic [wpvt_pkg::IDX_W-1:0]          target_index
);

    // no velocity means all-zero components
    `WPVT_ASSERT_IMP(a_zero_vel, clk, rst_n, out_valid && !vel_valid, (vel_x == 0) && (vel_y == 0) && (vel_z == 0))

    // reaching an intermediate waypoint issues no velocity
    `WPVT_ASSERT_IMP(a_mid_reach, clk, rst_n, out_valid && reached && !finished, !vel_valid)

    // a velocity with the path finished only comes from reaching the last waypoint
    `WPVT_ASSERT_IMP(a_fin_vel, clk, rst_n, out_valid && vel_valid && finished, reached && (vel_x == 0))

    // a stalled item stays with its index
    `WPVT_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(target_index))

endmodule

bind waypoint_p_velocity_tracker_top wpvt_checker u_wpvt_checker (.*);
